/* rtl/core/wsdf_pkg.sv */
// WebSocket frame deframer: shared types and constants.
// Used by the parser, the result register and the top level.
package wsdf_pkg;

    // Parser phases
    typedef enum logic [3:0] {
        PH_HDR0  = 4'd0,
        PH_HDR1  = 4'd1,
        PH_LENHI = 4'd2,
        PH_LENLO = 4'd3,
        PH_KEY0  = 4'd4,
        PH_KEY1  = 4'd5,
        PH_KEY2  = 4'd6,
        PH_KEY3  = 4'd7,
        PH_DATA  = 4'd8,
        PH_DEAD  = 4'd9
    } phase_t;

    // Result event codes
    localparam logic [1:0] EV_DATA      = 2'd0;
    localparam logic [1:0] EV_EMPTY     = 2'd1;
    localparam logic [1:0] EV_OVERSIZE  = 2'd2;
    localparam logic [1:0] EV_FRAGMENT  = 2'd3;

    // Header field constants
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    // One result beat
    typedef struct packed {
        logic [1:0] event_res;
        logic [7:0] data_byte;
        logic [3:0] frame_opcode;
        logic       frame_end;
    } res_t;

endpackage

/* rtl/core/wsdf_rx_if.sv */
// Receive byte channel: valid/ready handshake carrying one stream byte.
// Depends on nothing.
interface wsdf_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

/* rtl/core/wsdf_res_if.sv */
// Result channel: valid/ready handshake carrying one deframed result beat.
// Depends on nothing.
interface wsdf_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    logic [7:0] data_byte;
    logic [3:0] frame_opcode;
    logic       frame_end;

    modport source (output valid, output event_res, output data_byte,
                    output frame_opcode, output frame_end, input ready);
    modport sink   (input valid, input event_res, input data_byte,
                    input frame_opcode, input frame_end, output ready);
endinterface

/* rtl/core/wsdf_parser.sv */
// Frame header parser and payload unmasker: holds the frame state and
// computes at most one result per accepted byte. Depends on wsdf_pkg.
module wsdf_parser (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    rx_byte,
    output logic          res_valid,
    output wsdf_pkg::res_t res
);

    wsdf_pkg::phase_t phase_reg, phase_next;
    logic        fin_reg, fin_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        mask_reg, mask_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] count_reg, count_next;
    logic [31:0] key_reg, key_next;

    logic        len_known;
    logic [15:0] count_inc;
    logic [7:0]  key_byte;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= wsdf_pkg::PH_HDR0;
            fin_reg    <= 1'b0;
            opcode_reg <= 4'd0;
            mask_reg   <= 1'b0;
            length_reg <= 16'd0;
            count_reg  <= 16'd0;
            key_reg    <= 32'd0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            fin_reg    <= fin_next;
            opcode_reg <= opcode_next;
            mask_reg   <= mask_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            key_reg    <= key_next;
        end
    end

    // Key byte for the current payload position; key byte 0 sits on top
    always_comb
    begin
        case (count_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    assign count_inc = count_reg + 16'd1;

    // Next state and result
    always_comb
    begin
        phase_next  = phase_reg;
        fin_next    = fin_reg;
        opcode_next = opcode_reg;
        mask_next   = mask_reg;
        length_next = length_reg;
        count_next  = count_reg;
        key_next    = key_reg;
        len_known   = 1'b0;
        res_valid   = 1'b0;
        res.event_res    = wsdf_pkg::EV_DATA;
        res.data_byte    = 8'd0;
        res.frame_opcode = opcode_reg;
        res.frame_end    = 1'b1;

        case (phase_reg)
            wsdf_pkg::PH_HDR0:
            begin
                fin_next    = rx_byte[7];
                opcode_next = rx_byte[3:0];
                phase_next  = wsdf_pkg::PH_HDR1;
            end
            wsdf_pkg::PH_HDR1:
            begin
                mask_next = rx_byte[7];
                key_next  = 32'd0;
                if (rx_byte[6:0] == wsdf_pkg::LEN_CODE_64)
                begin
                    phase_next    = wsdf_pkg::PH_DEAD;
                    res_valid     = 1'b1;
                    res.event_res = wsdf_pkg::EV_OVERSIZE;
                end
                else if (rx_byte[6:0] == wsdf_pkg::LEN_CODE_16)
                begin
                    phase_next = wsdf_pkg::PH_LENHI;
                end
                else
                begin
                    length_next = {9'd0, rx_byte[6:0]};
                    len_known   = 1'b1;
                end
            end
            wsdf_pkg::PH_LENHI:
            begin
                length_next = {rx_byte, 8'd0};
                phase_next  = wsdf_pkg::PH_LENLO;
            end
            wsdf_pkg::PH_LENLO:
            begin
                length_next = {length_reg[15:8], rx_byte};
                len_known   = 1'b1;
            end
            wsdf_pkg::PH_KEY0:
            begin
                key_next   = {key_reg[23:0], rx_byte};
                phase_next = wsdf_pkg::PH_KEY1;
            end
            wsdf_pkg::PH_KEY1:
            begin
                key_next   = {key_reg[23:0], rx_byte};
                phase_next = wsdf_pkg::PH_KEY2;
            end
            wsdf_pkg::PH_KEY2:
            begin
                key_next   = {key_reg[23:0], rx_byte};
                phase_next = wsdf_pkg::PH_KEY3;
            end
            wsdf_pkg::PH_KEY3:
            begin
                key_next   = {key_reg[23:0], rx_byte};
                count_next = 16'd0;
                if (length_reg == 16'd0)
                begin
                    phase_next    = wsdf_pkg::PH_HDR0;
                    res_valid     = 1'b1;
                    res.event_res = wsdf_pkg::EV_EMPTY;
                end
                else
                begin
                    phase_next = wsdf_pkg::PH_DATA;
                end
            end
            wsdf_pkg::PH_DATA:
            begin
                count_next    = count_inc;
                res_valid     = 1'b1;
                res.event_res = wsdf_pkg::EV_DATA;
                res.data_byte = mask_reg ? (rx_byte ^ key_byte) : rx_byte;
                res.frame_end = (count_inc >= length_reg);
                if (count_inc >= length_reg)
                    phase_next = wsdf_pkg::PH_HDR0;
            end
            default:
            begin
                phase_next = wsdf_pkg::PH_DEAD;
            end
        endcase

        // Length complete: refuse fragments, then key, payload or empty frame
        if (len_known)
        begin
            if (!fin_reg)
            begin
                phase_next    = wsdf_pkg::PH_DEAD;
                res_valid     = 1'b1;
                res.event_res = wsdf_pkg::EV_FRAGMENT;
            end
            else
            begin
                count_next = 16'd0;
                if (mask_next)
                    phase_next = wsdf_pkg::PH_KEY0;
                else if (length_next == 16'd0)
                begin
                    phase_next    = wsdf_pkg::PH_HDR0;
                    res_valid     = 1'b1;
                    res.event_res = wsdf_pkg::EV_EMPTY;
                end
                else
                    phase_next = wsdf_pkg::PH_DATA;
            end
        end
    end

endmodule

/* rtl/core/wsdf_out_reg.sv */
// Result register: holds one result beat until the consumer takes it.
// Depends on wsdf_pkg.
module wsdf_out_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  wsdf_pkg::res_t res,
    input  logic           take,
    output logic           full,
    output wsdf_pkg::res_t res_q
);

    logic           full_reg;
    wsdf_pkg::res_t data_reg;

    // Valid flag: set on load, cleared when taken without a new load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else if (load)
            full_reg <= 1'b1;
        else if (take)
            full_reg <= 1'b0;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

    assign full  = full_reg;
    assign res_q = data_reg;

endmodule

/* rtl/core/websocket_frame_deframer_core.sv */
// WebSocket frame deframer, top level.
// A result is registered and presented in the cycle after the byte that causes it.
// Throughput: one byte per cycle while result.ready is held high, set by the
// single result register, which is reloaded in the same cycle its beat is taken.
// Reset: rst_n clears the parser to expect a frame header and empties the
// result register; after a refused frame all bytes are dropped until reset.
module websocket_frame_deframer_core (
    input  logic        clk,
    input  logic        rst_n,
    wsdf_rx_if.sink     rx,
    wsdf_res_if.source  result
);

    logic           accept;
    logic           res_valid;
    logic           full;
    logic           take;
    wsdf_pkg::res_t res;
    wsdf_pkg::res_t res_q;

    // Handshake: take a byte when the result register is empty or draining
    assign take     = full & result.ready;
    assign rx.ready = ~full | result.ready;
    assign accept   = rx.valid & rx.ready;

    wsdf_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx.rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    wsdf_out_reg u_out_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (accept & res_valid),
        .res   (res),
        .take  (take),
        .full  (full),
        .res_q (res_q)
    );

    assign result.valid        = full;
    assign result.event_res    = res_q.event_res;
    assign result.data_byte    = res_q.data_byte;
    assign result.frame_opcode = res_q.frame_opcode;
    assign result.frame_end    = res_q.frame_end;

endmodule
